[hw/rtl/tsp_pkg.sv]
// Shared types and constants for the TLV stream parser.
package tsp_pkg;

	localparam int MAX_RECORDS_DEF     = 16;
	localparam int MAX_VALUE_BYTES_DEF = 256;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_MANY  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic       value_valid;
		logic [3:0] record_index;
		logic [7:0] record_type;
		logic [7:0] value_offset;
		logic [7:0] value_out;
		logic       value_end;
		logic       done_res;
		logic [1:0] status;
		logic [4:0] record_count;
	} out_beat_t;

endpackage

[hw/rtl/tlv_stream_parser_top.sv]
// Channel  Signals                          Direction  Beat
// in       in_valid, in_ready, in_data      sink       one message byte, last flag
// out      out_valid, out_ready, out_data   source     value byte and/or end report
//
// One byte per cycle sustained while no result waits: a byte goes into the input
// register, the parser state and the result are settled from it combinationally,
// and the result lands in the output register, which stalls the input register
// only while a result waits; bytes without a result still need the output side free.
// Reset (arst_n low) returns the parser to expect a type byte with no records counted.
module tlv_stream_parser_top
	import tsp_pkg::*;
#(
	parameter int MAX_RECORDS     = MAX_RECORDS_DEF,
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [5:0] {
		PH_TYPE   = 6'b000001,
		PH_LEN_HI = 6'b000010,
		PH_LEN_LO = 6'b000100,
		PH_VALUE  = 6'b001000,
		PH_SKIP   = 6'b010000,
		PH_FAILED = 6'b100000
	} phase_t;

	logic       valid_s1;
	in_beat_t   data_s1;
	logic       out_valid_q;
	out_beat_t  out_data_q;
	logic       out_free;
	logic       adv_s1;

	phase_t      phase_q, phase_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] remain_q, remain_n;
	logic [7:0]  pos_q, pos_n;
	logic [CNT_W-1:0] done_q, done_n;
	logic [1:0]  err_q, err_n;

	logic [15:0] len;
	logic [15:0] remain_dec;
	logic        vv;
	logic        vend;
	logic        produce;
	logic [1:0]  st;
	logic [EXT_W-1:0] idx_ext;
	logic [EXT_W-1:0] cnt_ext;
	out_beat_t   res;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign len        = {len_hi_q, data_s1.data_byte};
	assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : 16'd0;

	always_comb begin
		phase_n  = phase_q;
		type_n   = type_q;
		len_hi_n = len_hi_q;
		remain_n = remain_q;
		pos_n    = pos_q;
		done_n   = done_q;
		err_n    = err_q;
		vv       = 1'b0;
		vend     = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				if (done_q >= CNT_W'(MAX_RECORDS)) begin
					err_n   = ST_TOO_MANY;
					phase_n = PH_FAILED;
				end else begin
					type_n  = data_s1.data_byte;
					pos_n   = 8'd0;
					phase_n = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				len_hi_n = data_s1.data_byte;
				phase_n  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				remain_n = len;
				pos_n    = 8'd0;
				if (len == 16'd0) begin
					done_n  = done_q + CNT_W'(1);
					phase_n = PH_TYPE;
				end else if (len > 16'(MAX_VALUE_BYTES)) begin
					phase_n = PH_SKIP;
				end else begin
					phase_n = PH_VALUE;
				end
			end
			PH_VALUE: begin
				// drop a final byte that cuts the value short
				if (!(data_s1.last_byte && remain_q > 16'd1)) begin
					vv       = 1'b1;
					vend     = (remain_q <= 16'd1);
					remain_n = remain_dec;
					pos_n    = pos_q + 8'd1;
					if (remain_q <= 16'd1) begin
						done_n  = done_q + CNT_W'(1);
						phase_n = PH_TYPE;
					end
				end
			end
			PH_SKIP: begin
				remain_n = remain_dec;
				if (remain_dec == 16'd0) begin
					err_n   = ST_TOO_LONG;
					phase_n = PH_FAILED;
				end
			end
			PH_FAILED: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st      = (phase_n == PH_TYPE || phase_n == PH_FAILED) ? err_n : ST_TRUNCATED;
		idx_ext = EXT_W'(done_q);
		cnt_ext = EXT_W'(done_n);
		produce = vv || data_s1.last_byte;

		res.value_valid  = vv;
		res.record_index = vv ? idx_ext[3:0] : 4'd0;
		res.record_type  = vv ? type_q : 8'd0;
		res.value_offset = vv ? pos_q : 8'd0;
		res.value_out    = vv ? data_s1.data_byte : 8'd0;
		res.value_end    = vend;
		res.done_res     = data_s1.last_byte;
		res.status       = data_s1.last_byte ? st : ST_OK;
		res.record_count = (data_s1.last_byte && st == ST_OK) ? cnt_ext[4:0] : 5'd0;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// parser state; the end of a message restores reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			type_q   <= 8'd0;
			len_hi_q <= 8'd0;
			remain_q <= 16'd0;
			pos_q    <= 8'd0;
			done_q   <= '0;
			err_q    <= ST_OK;
		end else if (adv_s1) begin
			if (data_s1.last_byte) begin
				phase_q  <= PH_TYPE;
				type_q   <= 8'd0;
				len_hi_q <= 8'd0;
				remain_q <= 16'd0;
				pos_q    <= 8'd0;
				done_q   <= '0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= phase_n;
				type_q   <= type_n;
				len_hi_q <= len_hi_n;
				remain_q <= remain_n;
				pos_q    <= pos_n;
				done_q   <= done_n;
				err_q    <= err_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
